### src/assert_macros.svh
// assertion macros shared by the hasher rtl
// expects a clock named clock and an active-high reset named reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication check
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication check
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

### src/sha256_pkg.sv
// types and constants for the sha-256 byte stream hasher
// no dependencies; used by sha256_core and the top level
package sha256_pkg;

   typedef logic [31:0] word_type;

   // commands from the byte sequencer to the compression core
   typedef struct packed {
      logic       shift_byte;
      logic [7:0] byte_data;
      logic       start;
      logic       init_chain;
   } core_cmd_type;

   // status from the compression core
   typedef struct packed {
      logic busy;
      logic done;
   } core_stat_type;

   // round constants
   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // initial hash values
   localparam word_type INIT_CHAIN [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;

endpackage

### src/sha256_byte_stream_hasher.sv
// sha-256 byte stream hasher: at most one byte per item, digest on the item marked last.
// a byte item that does not complete a block only shifts its byte in; one that
// completes a 64-byte block is loaded, then the core is started, runs 64 rounds and
// adds the chain before a new item is taken. a last item adds pad bytes up to the
// block end and one or two compressions, then loads the digest register.
// synchronous active-high reset restores the initial hash values and clears counts.
`include "assert_macros.svh"

module sha256_byte_stream_hasher (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] byte_present
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata    // [63:0] digest_part_0, [127:64] digest_part_1,
                                     // [191:128] digest_part_2, [255:192] digest_part_3
);
   import sha256_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PAD  = 3'd1;
   localparam logic [2:0] S_KICK = 3'd2;
   localparam logic [2:0] S_WAIT = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bits_ff, bits_in;
   logic         last_pend_ff, last_pend_in;
   logic         sent80_ff, sent80_in;
   logic         len_ok_ff, len_ok_in;
   logic         final_ff, final_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [255:0] rsp_data_ff, rsp_data_in;

   core_cmd_type  core_cmd;
   core_stat_type core_stat;
   logic [255:0]  chain_flat;

   logic       accept;
   logic       in_len;
   logic [2:0] len_idx;
   logic [7:0] pad_byte;
   logic       out_free;

   sha256_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cmd        (core_cmd),
      .stat       (core_stat),
      .chain_flat (chain_flat)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // padding byte: marker, zeros, then the bit length most significant byte first
   assign in_len   = sent80_ff && len_ok_ff && (fill_ff >= LEN_POS);
   assign len_idx  = 3'd7 - fill_ff[2:0];
   assign pad_byte = !sent80_ff ? PAD_MARK : (in_len ? bits_ff[{len_idx, 3'b000} +: 8] : 8'h00);

   // digest word order: part 0 holds chain words 0 and 1, word 0 in the top half
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rsp_data_in[64*i +: 64] = {chain_flat[64*i +: 32], chain_flat[64*i + 32 +: 32]};
      end
   end

   // byte sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      last_pend_in = last_pend_ff;
      sent80_in    = sent80_ff;
      len_ok_in    = len_ok_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      core_cmd     = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_pend_in = req_tlast;
               sent80_in    = 1'b0;
               len_ok_in    = 1'b0;
               final_in     = 1'b0;
               if (req_tuser) begin
                  core_cmd.shift_byte = 1'b1;
                  core_cmd.byte_data  = req_tdata;
                  fill_in             = fill_ff + 6'd1;
                  bits_in             = bits_ff + 64'd8;
               end
               if (req_tuser && (fill_ff == LAST_POS)) begin
                  state_in = S_KICK;
               end else if (req_tlast) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            core_cmd.shift_byte = 1'b1;
            core_cmd.byte_data  = pad_byte;
            fill_in             = fill_ff + 6'd1;
            if (!sent80_ff) begin
               sent80_in = 1'b1;
               len_ok_in = (fill_ff < LEN_POS);
            end
            if (fill_ff == LAST_POS) begin
               final_in = in_len;
               state_in = S_KICK;
            end
         end
         S_KICK: begin
            core_cmd.start = 1'b1;
            state_in       = S_WAIT;
         end
         S_WAIT: begin
            if (core_stat.done) begin
               if (final_ff) begin
                  state_in = S_EMIT;
               end else if (sent80_ff) begin
                  len_ok_in = 1'b1;
                  state_in  = S_PAD;
               end else if (last_pend_ff) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               core_cmd.init_chain = 1'b1;
               bits_in             = '0;
               final_in            = 1'b0;
               last_pend_in        = 1'b0;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         bits_ff      <= '0;
         last_pend_ff <= 1'b0;
         sent80_ff    <= 1'b0;
         len_ok_ff    <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         last_pend_ff <= last_pend_in;
         sent80_ff    <= sent80_in;
         len_ok_ff    <= len_ok_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // digest output register
   always_ff @(posedge clock) begin
      if ((state_ff == S_EMIT) && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMPLIES(a_core_idle_on_accept, req_tready, !core_stat.busy)
   `ASSERT_IMPLIES(a_done_only_waiting, core_stat.done, state_ff == S_WAIT)
   `ASSERT_IMPLIES(a_digest_from_emit, $rose(rsp_valid_ff), $past(state_ff) == S_EMIT)
   `ASSERT_NEXT(a_counts_clear_after_digest, (state_ff == S_EMIT) && out_free,
                (fill_ff == 6'd0) && (bits_ff == 64'd0))

endmodule

### src/sha256_core.sv
// sha-256 compression core: 512-bit block shift line, one round per cycle
// depends on sha256_pkg and assert_macros.svh
`include "assert_macros.svh"

module sha256_core (
   input  logic                      clock,
   input  logic                      reset,
   input  sha256_pkg::core_cmd_type  cmd,
   output sha256_pkg::core_stat_type stat,
   output logic [255:0]              chain_flat
);
   import sha256_pkg::*;

   localparam logic [1:0] C_IDLE  = 2'd0;
   localparam logic [1:0] C_ROUND = 2'd1;
   localparam logic [1:0] C_ADD   = 2'd2;

   logic [1:0]   c_state_ff, c_state_in;
   logic [5:0]   round_ff, round_in;
   logic [511:0] sched_ff, sched_in;
   word_type     work_ff [8];
   word_type     work_in [8];
   word_type     chain_ff [8];
   word_type     chain_in [8];

   word_type w_cur, w_1, w_9, w_14, w_new, sig0, sig1;
   word_type big0, big1, choose, major, t1, t2;

   function automatic word_type rotr(input word_type v, input int n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   // message schedule taps, oldest word at the top of the line
   assign w_cur = sched_ff[511:480];
   assign w_1   = sched_ff[479:448];
   assign w_9   = sched_ff[223:192];
   assign w_14  = sched_ff[63:32];
   assign sig0  = rotr(w_1, 7) ^ rotr(w_1, 18) ^ (w_1 >> 3);
   assign sig1  = rotr(w_14, 17) ^ rotr(w_14, 19) ^ (w_14 >> 10);
   assign w_new = sig1 + w_9 + sig0 + w_cur;

   // round function on the working variables
   assign big1   = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
   assign choose = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign t1     = work_ff[7] + big1 + choose + ROUND_K[round_ff] + w_cur;
   assign big0   = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
   assign major  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                 ^ (work_ff[1] & work_ff[2]);
   assign t2     = big0 + major;

   // sequencer and datapath next values
   always_comb begin
      c_state_in = c_state_ff;
      round_in   = round_ff;
      sched_in   = sched_ff;
      work_in    = work_ff;
      chain_in   = chain_ff;
      if (cmd.shift_byte) begin
         sched_in = {sched_ff[503:0], cmd.byte_data};
      end
      if (cmd.init_chain) begin
         chain_in = INIT_CHAIN;
      end
      case (c_state_ff)
         C_IDLE: begin
            if (cmd.start) begin
               work_in    = chain_ff;
               round_in   = '0;
               c_state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            sched_in   = {sched_ff[479:0], w_new};
            round_in   = round_ff + 6'd1;
            if (round_ff == LAST_POS) begin
               c_state_in = C_ADD;
            end
         end
         C_ADD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            c_state_in = C_IDLE;
         end
         default: begin
            c_state_in = C_IDLE;
         end
      endcase
   end

   // control and chain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         c_state_ff <= C_IDLE;
         round_ff   <= '0;
         chain_ff   <= INIT_CHAIN;
      end else begin
         c_state_ff <= c_state_in;
         round_ff   <= round_in;
         chain_ff   <= chain_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      work_ff  <= work_in;
   end

   assign stat.busy = (c_state_ff != C_IDLE);
   assign stat.done = (c_state_ff == C_ADD);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         chain_flat[32*i +: 32] = chain_ff[i];
      end
   end

   `ASSERT_IMPLIES(a_start_when_idle, cmd.start, c_state_ff == C_IDLE)
   `ASSERT_IMPLIES(a_no_shift_in_rounds, cmd.shift_byte, c_state_ff == C_IDLE)
   `ASSERT_NEXT(a_add_after_last_round, (c_state_ff == C_ROUND) && (round_ff == LAST_POS),
                (c_state_ff == C_ADD) && (round_ff == 6'd0))

endmodule
